@@ rtl/dlc_pkg.sv @@
// Shared types and constants for the decimal literal classifier.
// Holds the byte token format, the result kinds and the keyword table.
// Depends on nothing; every other file imports it.
package dlc_pkg;

	// Result kinds
	localparam logic [2:0] KIND_EMPTY = 3'd0;
	localparam logic [2:0] KIND_TRUE  = 3'd1;
	localparam logic [2:0] KIND_FALSE = 3'd2;
	localparam logic [2:0] KIND_NULL  = 3'd3;
	localparam logic [2:0] KIND_UINT  = 3'd4;
	localparam logic [2:0] KIND_SINT  = 3'd5;
	localparam logic [2:0] KIND_FLOAT = 3'd6;

	// Keyword table: true, false, null
	localparam int KW_NUM = 3;
	localparam int KW_POS = 5;
	localparam logic [2:0] LEN_SAT = 3'd6;
	localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd4, 3'd5, 3'd4};
	localparam logic [7:0] KW_TEXT [KW_NUM][KW_POS] = '{
		'{8'h74, 8'h72, 8'h75, 8'h65, 8'h00},
		'{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65},
		'{8'h6E, 8'h75, 8'h6C, 8'h6C, 8'h00}
	};

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CASE_GAP = 8'h20;

	// Largest accumulator that can still take a digit, and the largest digit at it
	localparam logic [63:0] ACC_LIM   = 64'h1999_9999_9999_9999;
	localparam logic [3:0]  DIGIT_LIM = 4'd5;

	// Queue depth between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Decoded byte token handed from front to back
	typedef struct packed {
		logic                           has;
		logic                           last;
		logic                           hint;
		logic                           blank;
		logic                           minus;
		logic                           is_digit;
		logic [3:0]                     digit;
		logic [KW_POS-1:0][KW_NUM-1:0]  kw_hit;  // per position, per keyword
	} dlc_tok_t;

	// Final field state handed to the output stage
	typedef struct packed {
		logic [63:0]        acc;
		logic               neg;
		logic               bad;
		logic               hint;
		logic [2:0]         len;
		logic [KW_NUM-1:0]  kw;
	} dlc_fin_t;

endpackage

@@ rtl/dlc_front.sv @@
// Front part: decodes one input byte into a token for the back part.
// Flags whitespace, minus and digits and compares against the keyword table.
// Depends on dlc_pkg.
module dlc_front
	import dlc_pkg::*;
(
	input  logic [7:0] char_byte,
	input  logic       has_byte,
	input  logic       last_byte,
	input  logic       float_hint,
	output dlc_tok_t   tok
);

	// Compare the byte against every keyword letter at every position
	always_comb begin
		tok.has      = has_byte;
		tok.last     = last_byte;
		tok.hint     = float_hint;
		tok.blank    = (char_byte == CH_SPACE) || (char_byte >= CH_TAB && char_byte <= CH_CR);
		tok.minus    = (char_byte == CH_MINUS);
		tok.is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
		tok.digit    = 4'(char_byte - CH_ZERO);
		for (int p = 0; p < KW_POS; p++) begin
			for (int k = 0; k < KW_NUM; k++) begin
				tok.kw_hit[p][k] = (3'(p) < KW_LEN[k]) &&
					((char_byte == KW_TEXT[k][p]) ||
					 (p == 0 && char_byte == 8'(KW_TEXT[k][p] - CASE_GAP)));
			end
		end
	end

endmodule

@@ rtl/dlc_queue.sv @@
// Short token queue between the front and back parts.
// Lets either side stall without holding up the other. Depends on dlc_pkg.
module dlc_queue
	import dlc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  dlc_tok_t push_tok,
	output logic     full,
	input  logic     pop,
	output logic     avail,
	output dlc_tok_t head_tok
);

	dlc_tok_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QPTR_W:0]       count_q;

	assign full     = (count_q == (QPTR_W+1)'(QDEPTH));
	assign avail    = (count_q != '0);
	assign head_tok = mem_q[rd_ptr_q];

	// Store incoming tokens
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/dlc_back.sv @@
// Back part: carries out tokens on the field state, then classifies the field.
// Holds the accumulator, phase, flags, a finish stage and the result register.
// Depends on dlc_pkg.
module dlc_back
	import dlc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        avail,
	input  dlc_tok_t    tok,
	output logic        pop,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  res_kind,
	output logic [63:0] res_value
);

	typedef enum logic [2:0] {
		PH_LEAD  = 3'b001,
		PH_BODY  = 3'b010,
		PH_TRAIL = 3'b100
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [63:0]       acc_q, acc_d;
	logic              neg_q, neg_d;
	logic              bad_q, bad_d;
	logic [2:0]        len_q, len_d;
	logic [KW_NUM-1:0] kw_q, kw_d;

	logic              fin_valid_s1;
	dlc_fin_t          fin_s1;
	logic              out_valid_s2;
	logic [2:0]        kind_s2;
	logic [63:0]       value_s2;

	logic              out_free;
	logic              fin_ready;
	logic              fin_adv;
	logic [KW_NUM-1:0] hit;
	logic [2:0]        kind_c;
	logic [63:0]       value_c;

	// Pop a token unless it ends a field and the finish stage is blocked
	assign out_free  = !out_valid_s2 || res_ready;
	assign fin_adv   = fin_valid_s1 && out_free;
	assign fin_ready = !fin_valid_s1 || out_free;
	assign pop       = avail && (!tok.last || fin_ready);

	// Next field state for the token at the head of the queue
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		bad_d   = bad_q;
		len_d   = len_q;
		kw_d    = kw_q;
		hit     = (len_q < 3'(KW_POS)) ? tok.kw_hit[len_q] : '0;
		if (tok.has) begin
			if (tok.blank) begin
				if (phase_q == PH_BODY) begin
					phase_d = PH_TRAIL;
				end
			end else begin
				// content after trailing space spoils the field
				if (phase_q == PH_TRAIL) begin
					kw_d  = '0;
					bad_d = 1'b1;
				end
				phase_d = PH_BODY;
				kw_d    = kw_d & hit;
				if (!bad_d) begin
					if (len_q == '0 && tok.minus) begin
						neg_d = 1'b1;
					end else if (tok.is_digit) begin
						if (acc_q > ACC_LIM || (acc_q == ACC_LIM && tok.digit > DIGIT_LIM)) begin
							bad_d = 1'b1;
						end else begin
							acc_d = (acc_q << 3) + (acc_q << 1) + 64'(tok.digit);
						end
					end else begin
						bad_d = 1'b1;
					end
				end
				if (len_q < LEN_SAT) begin
					len_d = len_q + 1'b1;
				end
			end
		end
	end

	// Update field state; return to the idle field state after the last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			bad_q   <= 1'b0;
			len_q   <= '0;
			kw_q    <= '1;
		end else if (pop) begin
			if (tok.last) begin
				phase_q <= PH_LEAD;
				acc_q   <= '0;
				neg_q   <= 1'b0;
				bad_q   <= 1'b0;
				len_q   <= '0;
				kw_q    <= '1;
			end else begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				neg_q   <= neg_d;
				bad_q   <= bad_d;
				len_q   <= len_d;
				kw_q    <= kw_d;
			end
		end
	end

	// Finish stage: hold the final field state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s1 <= 1'b0;
		end else if (pop && tok.last) begin
			fin_valid_s1 <= 1'b1;
		end else if (fin_adv) begin
			fin_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && tok.last) begin
			fin_s1.acc  <= acc_d;
			fin_s1.neg  <= neg_d;
			fin_s1.bad  <= bad_d;
			fin_s1.hint <= tok.hint;
			fin_s1.len  <= len_d;
			fin_s1.kw   <= kw_d;
		end
	end

	// Classify the finished field
	always_comb begin
		kind_c  = KIND_FLOAT;
		value_c = '0;
		if (fin_s1.len == '0) begin
			kind_c = KIND_EMPTY;
		end else if (fin_s1.kw[0] && fin_s1.len == KW_LEN[0]) begin
			kind_c = KIND_TRUE;
		end else if (fin_s1.kw[1] && fin_s1.len == KW_LEN[1]) begin
			kind_c = KIND_FALSE;
		end else if (fin_s1.kw[2] && fin_s1.len == KW_LEN[2]) begin
			kind_c = KIND_NULL;
		end else if (!fin_s1.hint && !fin_s1.bad) begin
			if (!fin_s1.neg) begin
				kind_c  = KIND_UINT;
				value_c = fin_s1.acc;
			end else if (fin_s1.len >= 3'd2 && !fin_s1.acc[63]) begin
				kind_c  = KIND_SINT;
				value_c = '0 - fin_s1.acc;
			end
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= fin_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_adv) begin
			kind_s2  <= kind_c;
			value_s2 <= value_c;
		end
	end

	assign res_valid = out_valid_s2;
	assign res_kind  = kind_s2;
	assign res_value = value_s2;

endmodule

@@ rtl/decimal_literal_classifier.sv @@
// Top level of the decimal literal classifier.
// Joins the byte decoder, the token queue and the back part. Depends on dlc_pkg.
//
//   channel   dir  tdata              tuser                      tlast
//   s_*       in   char_byte[7:0]     has_byte, float_hint       last_byte
//   m_*       out  value[63:0]        kind[2:0]                  (none)
//
// One byte item is taken per cycle while s_tready is high, as the back part
// does one multiply-by-ten and add per cycle. A result is offered on m_tvalid
// after its last item has passed the queue, finish stage and result register.
// Reset clears queue and field state; s_tready drops only when the four-entry
// queue is full, which happens while the result register waits on m_tready.
module decimal_literal_classifier
	import dlc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	input  logic [1:0]  s_tuser,   // [0] has_byte, [1] float_hint
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] value
	output logic [2:0]  m_tuser    // [2:0] kind
);

	dlc_tok_t in_tok;
	dlc_tok_t head_tok;
	logic     q_full;
	logic     q_avail;
	logic     q_pop;
	logic     push;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// Decode each byte item
	dlc_front u_front (
		.char_byte  (s_tdata),
		.has_byte   (s_tuser[0]),
		.last_byte  (s_tlast),
		.float_hint (s_tuser[1]),
		.tok        (in_tok)
	);

	// Buffer tokens between the two parts
	dlc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (in_tok),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.head_tok (head_tok)
	);

	// Parse and classify
	dlc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (q_avail),
		.tok       (head_tok),
		.pop       (q_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_kind  (m_tuser),
		.res_value (m_tdata)
	);

endmodule
